// ===== rtl/csort_pkg.sv =====
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types, sizes and helpers for the comb sort engine.
// ----------------------------------------------------------------------------
package csort_pkg;

  // Store geometry
  localparam int DEPTH = 64;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Reciprocal of 13 for the gap shrink: q = (p * RECIP13) >> RSHIFT.
  // The result is exact for every p below 2**RSHIFT / 10.
  localparam int RSHIFT  = 16;
  localparam int RECIP13 = ((1 << RSHIFT) + 12) / 13;
  localparam int RW      = $clog2(RECIP13 + 1);
  localparam int PW      = CW + 4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_SWAP,
    ST_DRAIN
  } csort_state_t;

  // Memory commands from the sequencer; both copies get the same write
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
  } csort_mem_cmd_t;

  // Next gap: gap * 10 / 13, never below one
  function automatic logic [CW-1:0] shrink_gap(input logic [CW-1:0] gap);
    logic [PW-1:0]      prod10;
    logic [PW+RW-1:0]   prod;
    logic [PW+RW-1:0]   quo;
    prod10 = PW'(gap) * PW'(10);
    prod   = (PW+RW)'(prod10) * (PW+RW)'(RECIP13);
    quo    = prod >> RSHIFT;
    if (quo == '0) begin
      return CW'(1);
    end
    return quo[CW-1:0];
  endfunction

endpackage

// ===== rtl/csort_ram.sv =====
// ----------------------------------------------------------------------------
// csort_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/csort_ctrl.sv =====
// ----------------------------------------------------------------------------
// csort_ctrl
// Sequencer: loads the set, runs the comb sort passes over the store by
// read / compare / write-back steps, then reads the store out in order.
// ----------------------------------------------------------------------------
module csort_ctrl
  import csort_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [DW-1:0]  in_value,
  input  logic           in_last,
  input  logic [DW-1:0]  rdata_a,
  input  logic [DW-1:0]  rdata_b,
  output csort_mem_cmd_t mem_cmd,
  output logic           out_strobe,
  output logic           out_end_of_run,
  output logic           out_overflowed
);

  csort_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          swapped_r, swapped_nxt;
  logic [DW-1:0] hold_r, hold_nxt;
  logic          strobe_r, strobe_nxt;
  logic          end_r, end_nxt;
  logic          ovf_r, ovf_nxt;

  logic [CW:0]   pair_sum;
  logic [CW-1:0] count_inc;
  logic          accept;
  logic          full;

  assign accept    = start && (state_r == ST_LOAD);
  assign full      = (count_r == CW'(DEPTH));
  assign count_inc = full ? count_r : count_r + CW'(1);
  assign pair_sum  = (CW+1)'(idx_r) + (CW+1)'(gap_r);

  assign busy           = (state_r != ST_LOAD);
  assign out_strobe     = strobe_r;
  assign out_end_of_run = end_r;
  assign out_overflowed = ovf_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    gap_r     <= gap_nxt;
    idx_r     <= idx_nxt;
    swapped_r <= swapped_nxt;
    hold_r    <= hold_nxt;
    end_r     <= end_nxt;
    ovf_r     <= ovf_nxt;
  end

  // Next state and memory commands
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    gap_nxt     = gap_r;
    idx_nxt     = idx_r;
    swapped_nxt = swapped_r;
    hold_nxt    = hold_r;
    strobe_nxt  = 1'b0;
    end_nxt     = end_r;
    ovf_nxt     = ovf_r;

    mem_cmd         = '0;
    mem_cmd.raddr_a = idx_r;
    mem_cmd.raddr_b = pair_sum[AW-1:0];

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          // Store the element, or drop it when the store is full
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = count_r[AW-1:0];
            mem_cmd.wdata = in_value;
          end
          count_nxt = count_inc;
          if (in_last) begin
            gap_nxt     = shrink_gap(count_inc);
            swapped_nxt = 1'b0;
            idx_nxt     = '0;
            state_nxt   = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (pair_sum < (CW+1)'(count_r)) begin
          // Fetch the pair idx, idx + gap
          state_nxt = ST_CMP;
        end else if ((gap_r == CW'(1)) && !swapped_r) begin
          // Clean pass at gap one: sorted
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          gap_nxt     = shrink_gap(gap_r);
          swapped_nxt = 1'b0;
          idx_nxt     = '0;
        end
      end

      ST_CMP: begin
        if ($signed(rdata_a) > $signed(rdata_b)) begin
          // Swap: lower slot first, upper slot next cycle
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = idx_r;
          mem_cmd.wdata = rdata_b;
          hold_nxt      = rdata_a;
          swapped_nxt   = 1'b1;
          state_nxt     = ST_SWAP;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_READ;
        end
      end

      ST_SWAP: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pair_sum[AW-1:0];
        mem_cmd.wdata = hold_r;
        idx_nxt       = idx_r + AW'(1);
        state_nxt     = ST_READ;
      end

      ST_DRAIN: begin
        // One read per cycle; the strobe lines up with the read data
        strobe_nxt = 1'b1;
        ovf_nxt    = dropped_r;
        end_nxt    = ((CW'(idx_r) + CW'(1)) == count_r);
        if (end_nxt) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/comb_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// comb_sort_engine_core
// Collects signed 32-bit values into a 64-entry store, comb-sorts them
// ascending once the last one arrives, and streams the sorted set out.
// ----------------------------------------------------------------------------
// Usage: values are taken one per cycle while busy is low. The value marked
// last closes the set; busy then stays high while the sort runs and the set
// is read out, and drops in the cycle that shows the final result, so the
// next set may begin in that cycle. Each compare step has a memory read
// state and a compare state, a swap adds a state for the second write,
// and each pass ends with a closing step; sort time follows the number of
// passes times the pairs per pass. Results then leave one per
// cycle, one per stored element, each shown for a single cycle with
// out_strobe; the receiver cannot stall them. Values past 64 are dropped and
// every result of that set carries out_overflowed. The store is held in two
// mirrored RAMs so both elements of a pair are read in the same cycle.
// ----------------------------------------------------------------------------
module comb_sort_engine_core
  import csort_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] in_value,
  input  logic                 in_last,
  output logic                 out_strobe,
  output logic signed [DW-1:0] out_sorted_value,
  output logic                 out_end_of_run,
  output logic                 out_overflowed
);

  csort_mem_cmd_t mem_cmd;
  logic [DW-1:0]  rdata_a;
  logic [DW-1:0]  rdata_b;

  // Sequencer
  csort_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_last        (in_last),
    .rdata_a        (rdata_a),
    .rdata_b        (rdata_b),
    .mem_cmd        (mem_cmd),
    .out_strobe     (out_strobe),
    .out_end_of_run (out_end_of_run),
    .out_overflowed (out_overflowed)
  );

  // Store copy A: lower element of a pair, and the read-out port
  csort_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .raddr (mem_cmd.raddr_a),
    .rdata (rdata_a)
  );

  // Store copy B: upper element of a pair
  csort_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .raddr (mem_cmd.raddr_b),
    .rdata (rdata_b)
  );

  assign out_sorted_value = $signed(rdata_a);

endmodule

// ===== tb/comb_sort_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// comb_sort_engine_checker
// Watches the load and result channels of the comb sort engine, keeps its
// own copy of the element store, sorts each closed set and compares every
// result strobe against the oldest predicted value.
// ----------------------------------------------------------------------------
module comb_sort_engine_checker
  import csort_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [DW-1:0] in_value,
  input  logic                 in_last,
  input  logic                 out_strobe,
  input  logic signed [DW-1:0] out_sorted_value,
  input  logic                 out_end_of_run,
  input  logic                 out_overflowed,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  // One predicted result
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 end_of_run;
    logic                 overflowed;
  } sorted_result_t;

  sorted_result_t       sorted_q[$];
  logic signed [DW-1:0] held_vals [DEPTH];
  int                   held_count;
  logic                 set_dropped;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    held_count   = 0;
    set_dropped  = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 30) begin
      $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, msg);
    end
  endtask

  // Comb sort of the held set: gap shrinks by 10/13 down to one, and the
  // passes stop once a gap-one pass makes no swap.
  task automatic sort_held_set();
    int                   gap;
    int                   idx;
    logic                 swapped;
    logic signed [DW-1:0] tmp;
    gap     = held_count;
    swapped = 1'b1;
    while (gap != 1 || swapped) begin
      gap = (gap * 10) / 13;
      if (gap < 1) begin
        gap = 1;
      end
      swapped = 1'b0;
      for (idx = 0; idx + gap < held_count; idx++) begin
        if (held_vals[idx] > held_vals[idx + gap]) begin
          tmp                  = held_vals[idx];
          held_vals[idx]       = held_vals[idx + gap];
          held_vals[idx + gap] = tmp;
          swapped              = 1'b1;
        end
      end
    end
  endtask

  // Load transfer: store or drop, and on the last value predict the set
  task automatic load_value(input logic signed [DW-1:0] v, input logic is_last);
    sorted_result_t r;
    if (held_count < DEPTH) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      sort_held_set();
      for (int k = 0; k < held_count; k++) begin
        r.value      = held_vals[k];
        r.end_of_run = (k == held_count - 1);
        r.overflowed = set_dropped;
        sorted_q.push_back(r);
      end
      held_count  = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Result transfer: compare field by field with the oldest prediction
  task automatic check_result();
    sorted_result_t exp_r;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d", out_sorted_value));
    end else begin
      exp_r = sorted_q.pop_front();
      if (out_sorted_value !== exp_r.value) begin
        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                  out_sorted_value, exp_r.value));
      end
      if (out_end_of_run !== exp_r.end_of_run) begin
        report_mismatch($sformatf("end_of_run %b, expected %b",
                                  out_end_of_run, exp_r.end_of_run));
      end
      if (out_overflowed !== exp_r.overflowed) begin
        report_mismatch($sformatf("overflowed %b, expected %b",
                                  out_overflowed, exp_r.overflowed));
      end
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count  = 0;
      set_dropped = 1'b0;
      sorted_q.delete();
    end else begin
      if (start && !busy) begin
        load_value(in_value, in_last);
      end
      if (out_strobe) begin
        check_result();
      end
    end
    pending <= sorted_q.size();
  end

endmodule

// ===== tb/comb_sort_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// comb_sort_engine_core_tb
// Feeds sets of signed values to the comb sort engine: a few hand-picked
// sets first, then random sets of mostly small size plus full and
// over-capacity sets, under three sender idle profiles. The checker
// predicts and compares the sorted output; this module gives the verdict.
// ----------------------------------------------------------------------------
module comb_sort_engine_core_tb
  import csort_pkg::*;
();

  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam int PHASE_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic signed [DW-1:0] in_value = '0;
  logic                 in_last  = 1'b0;
  logic                 busy;
  logic                 out_strobe;
  logic signed [DW-1:0] out_sorted_value;
  logic                 out_end_of_run;
  logic                 out_overflowed;

  int fail_count;
  int pending;
  int results_seen;
  int values_sent   = 0;
  int sets_sent     = 0;
  int overflow_sets = 0;

  // Hand-picked sets: lone minimum, lone maximum, extremes, equal values,
  // descending run across zero, a pair, and repeated extremes
  int                   dir_sizes [7]  = '{1, 1, 5, 3, 8, 2, 4};
  logic signed [DW-1:0] dir_vals  [24] = '{
    VAL_MIN,
    VAL_MAX,
    VAL_MAX, VAL_MIN, -32'sd1, 32'sd0, 32'sd1,
    32'sd7, 32'sd7, 32'sd7,
    32'sd300, 32'sd200, 32'sd100, 32'sd0, -32'sd100, -32'sd200, -32'sd300, -32'sd400,
    32'sd5, -32'sd5,
    VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX
  };

  comb_sort_engine_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_overflowed   (out_overflowed)
  );

  comb_sort_engine_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_overflowed   (out_overflowed),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Value flavor per set: full range, narrow range with repeats, extremes, mixed
  function automatic logic signed [DW-1:0] pick_value(input int flavor);
    int f;
    f = (flavor == 3) ? $urandom_range(0, 2) : flavor;
    case (f)
      0: return $urandom;
      1: return DW'($urandom_range(0, 15)) - DW'(8);
      default: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One load transfer; each idle cycle ahead of it is drawn with idle_pct
  task automatic send_value(input logic signed [DW-1:0] v, input logic is_last,
                            input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    do @(posedge clk); while (busy);
    values_sent++;
  endtask

  task automatic send_random_set(input int set_len, input int idle_pct);
    int flavor;
    flavor = $urandom_range(0, 3);
    for (int i = 0; i < set_len; i++) begin
      send_value(pick_value(flavor), i == set_len - 1, idle_pct);
    end
    sets_sent++;
    if (set_len > DEPTH) begin
      overflow_sets++;
    end
  endtask

  // Hold the sender off until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int idle_pct;
    int pos;
    int phase_start;
    int set_len;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets
    pos = 0;
    foreach (dir_sizes[s]) begin
      for (int i = 0; i < dir_sizes[s]; i++) begin
        send_value(dir_vals[pos], i == dir_sizes[s] - 1, 29);
        pos++;
      end
      sets_sent++;
    end
    wait_drained();

    // Random sets; each phase opens with a full or over-capacity set
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct    = (phase == 0) ? 29 : (phase == 1) ? 47 : 0;
      phase_start = values_sent;
      send_random_set((phase == 0) ? DEPTH : (phase == 1) ? DEPTH + 1 : DEPTH + 3,
                      idle_pct);
      phase_start = values_sent;
      while (values_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          set_len = $urandom_range(1, 12);
        end else begin
          set_len = $urandom_range(13, 40);
        end
        send_random_set(set_len, idle_pct);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d values in %0d sets, %0d of them over store capacity,",
             values_sent, sets_sent, overflow_sets);
    $display("with %0d sorted results compared.", results_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csort_pkg.sv
rtl/csort_ram.sv
rtl/csort_ctrl.sv
rtl/comb_sort_engine_core.sv
tb/comb_sort_engine_checker.sv
tb/comb_sort_engine_core_tb.sv
